### hw/rtl/i2c_seq_pkg.sv
// Shared types and constants for the I2C master transaction sequencer.
// No dependencies; imported by i2c_master_transaction_sequencer.
package i2c_seq_pkg;

    // Request kinds carried in s_tuser
    typedef enum logic [2:0] {
        KIND_LOAD  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_READ  = 3'd2,
        KIND_EVENT = 3'd3,
        KIND_POP   = 3'd4
    } kind_t;

    // Bus actions returned with each result
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_ACK     = 3'd3,
        ACT_NACK    = 3'd4,
        ACT_STOP    = 3'd5,
        ACT_RESTART = 3'd6
    } action_t;

    // Bus status codes
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RESTART   = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
    localparam logic [7:0] ST_SLA_W_NAK = 8'h20;
    localparam logic [7:0] ST_DAT_W_ACK = 8'h28;
    localparam logic [7:0] ST_DAT_W_NAK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST  = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
    localparam logic [7:0] ST_SLA_R_NAK = 8'h48;
    localparam logic [7:0] ST_DAT_R_ACK = 8'h50;
    localparam logic [7:0] ST_DAT_R_NAK = 8'h58;

    // Byte returned by a pop from an empty receive buffer
    localparam logic [7:0] RX_EMPTY_BYTE = 8'h88;

endpackage

### hw/rtl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer: turns requests and bus status events into bus actions.
// Depends on i2c_seq_pkg for kinds, actions and status codes.
//
// Usage:
//   Slave channel (s_*) takes requests: s_tuser holds the kind (load tx byte, start write,
//   start read, bus status event, pop received byte), s_tdata the operand fields.
//   Master channel (m_*) returns exactly one result per request, in order: the bus
//   action, the byte to send, the popped byte and the busy / data / empty flags.
//   A request is registered on acceptance, processed against the transmit and receive
//   buffers (internal memories, one access each per request) once the result register is
//   free or being taken, and its result is registered; m_tvalid is the valid bit of that
//   result register, so each request passes the input register and then the result register.
//   Throughput is one request per cycle while m_tready stays high, as the pointers and
//   buffers are updated once per request. When the receiver stalls, the result register
//   holds and the input register holds one more request; s_tready drops once both are full.
//   Reset clears the pointers, counts, busy flag and both pipeline valid bits. Buffer
//   contents are not cleared; a data slot must be loaded before it is sent.
module i2c_master_transaction_sequencer
    import i2c_seq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // slot[3:0], data_byte[11:4], slave_address[18:12],
                                  // count[23:19], status_code[31:24]
    input  logic [2:0]  s_tuser,  // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // action[2:0], tx_byte[10:3], rx_byte[18:11],
                                  // busy_res[19], has_data[20], rx_empty[21], zero[23:22]
);

    localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int WW = ((CW > 5) ? CW : 5) + 1;

    localparam logic [WW-1:0] DEPTH_W    = WW'(BUFFER_DEPTH);
    localparam logic [WW-1:0] DEPTH_M1_W = WW'(BUFFER_DEPTH - 1);

    // Input register
    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic [2:0]  in_kind_reg;

    // Result register
    logic        out_valid_reg;
    logic [2:0]  action_reg;
    logic [7:0]  tx_byte_reg;
    logic [7:0]  rx_byte_reg;
    logic        busy_reg;
    logic        has_data_reg;
    logic        rx_empty_reg;

    // Sequencer state
    logic [CW-1:0] tx_total_reg, tx_total_next;
    logic [CW-1:0] tx_next_reg, tx_next_next;
    logic [CW-1:0] rx_expected_reg, rx_expected_next;
    logic [CW-1:0] rx_fill_reg, rx_fill_next;
    logic          in_progress_reg, in_progress_next;

    // Buffers
    logic [7:0] tx_mem [BUFFER_DEPTH];
    logic [7:0] rx_mem [BUFFER_DEPTH];

    logic advance;

    // Request fields
    logic [3:0] f_slot;
    logic [7:0] f_byte;
    logic [6:0] f_addr;
    logic [4:0] f_count;
    logic [7:0] f_code;

    // Combinational step outputs
    logic [2:0]    action_c;
    logic          rx_empty_c;
    logic          tx_rd_en, rx_rd_en, rx_empty_rd;
    logic [IW-1:0] tx_rd_addr, rx_rd_addr;
    logic          tx_wr_en, rx_wr_en;
    logic [IW-1:0] tx_wr_addr, rx_wr_addr;
    logic [7:0]    tx_wr_data;

    logic [WW-1:0] slot_p1;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] wr_cnt;
    logic [WW-1:0] rd_cnt;
    logic [CW-1:0] tn;
    logic [CW:0]   fill_p1;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign f_slot  = in_data_reg[3:0];
    assign f_byte  = in_data_reg[11:4];
    assign f_addr  = in_data_reg[18:12];
    assign f_count = in_data_reg[23:19];
    assign f_code  = in_data_reg[31:24];

    assign slot_p1 = WW'(f_slot) + WW'(1);
    assign cnt_w   = WW'(f_count);
    assign wr_cnt  = (cnt_w > DEPTH_M1_W) ? DEPTH_M1_W : cnt_w;
    assign rd_cnt  = (cnt_w > DEPTH_W) ? DEPTH_W : cnt_w;

    // Step logic: next state, action and buffer accesses for the registered request
    always_comb
    begin
        tx_total_next    = tx_total_reg;
        tx_next_next     = tx_next_reg;
        rx_expected_next = rx_expected_reg;
        rx_fill_next     = rx_fill_reg;
        in_progress_next = in_progress_reg;
        action_c         = ACT_NONE;
        rx_empty_c       = 1'b0;
        tx_rd_en         = 1'b0;
        tx_rd_addr       = '0;
        rx_rd_en         = 1'b0;
        rx_rd_addr       = '0;
        rx_empty_rd      = 1'b0;
        tx_wr_en         = 1'b0;
        tx_wr_addr       = '0;
        tx_wr_data       = f_byte;
        rx_wr_en         = 1'b0;
        rx_wr_addr       = rx_fill_reg[IW-1:0];
        tn               = tx_next_reg;
        fill_p1          = (CW + 1)'(rx_fill_reg) + (CW + 1)'(1);

        unique case (in_kind_reg)
            KIND_LOAD:
            begin
                if (slot_p1 < DEPTH_W)
                begin
                    tx_wr_en   = 1'b1;
                    tx_wr_addr = slot_p1[IW-1:0];
                end
            end
            KIND_WRITE:
            begin
                tx_wr_en         = 1'b1;
                tx_wr_data       = {f_addr, 1'b0};
                tx_total_next    = CW'(wr_cnt + WW'(1));
                in_progress_next = 1'b1;
                action_c         = ACT_START;
            end
            KIND_READ:
            begin
                tx_wr_en         = 1'b1;
                tx_wr_data       = {f_addr, 1'b1};
                tx_total_next    = CW'(1);
                rx_expected_next = CW'(rd_cnt);
                in_progress_next = 1'b1;
                action_c         = ACT_START;
            end
            KIND_EVENT:
            begin
                case (f_code)
                    ST_START, ST_RESTART, ST_SLA_W_ACK, ST_DAT_W_ACK:
                    begin
                        // A (re)start rewinds to the address byte
                        if (f_code == ST_START || f_code == ST_RESTART)
                        begin
                            tn = '0;
                        end
                        tx_next_next = tn;
                        if (tn < tx_total_reg)
                        begin
                            tx_rd_en     = 1'b1;
                            tx_rd_addr   = tn[IW-1:0];
                            tx_next_next = tn + CW'(1);
                            action_c     = ACT_SEND;
                        end
                        else
                        begin
                            in_progress_next = 1'b0;
                            action_c         = ACT_STOP;
                        end
                    end
                    ST_SLA_R_ACK:
                    begin
                        rx_fill_next = '0;
                        action_c = (rx_expected_reg == CW'(1)) ? ACT_NACK : ACT_ACK;
                    end
                    ST_DAT_R_ACK:
                    begin
                        // Capture unless full; ACK while more bytes are wanted
                        if (rx_fill_reg < CW'(BUFFER_DEPTH))
                        begin
                            rx_wr_en     = 1'b1;
                            rx_fill_next = fill_p1[CW-1:0];
                            fill_p1      = fill_p1 + (CW + 1)'(1);
                        end
                        action_c = (rx_expected_reg != '0 &&
                                    fill_p1 < (CW + 1)'(rx_expected_reg)) ? ACT_ACK : ACT_NACK;
                    end
                    ST_DAT_R_NAK:
                    begin
                        if (rx_fill_reg < CW'(BUFFER_DEPTH))
                        begin
                            rx_wr_en     = 1'b1;
                            rx_fill_next = fill_p1[CW-1:0];
                        end
                        in_progress_next = 1'b0;
                        action_c         = ACT_STOP;
                    end
                    ST_ARB_LOST:
                    begin
                        in_progress_next = 1'b0;
                        action_c         = ACT_RESTART;
                    end
                    default:
                    begin
                        in_progress_next = 1'b0;
                        action_c         = ACT_STOP;
                    end
                endcase
            end
            KIND_POP:
            begin
                // Last-in byte first; empty buffer returns the marker byte
                if (rx_fill_reg != '0)
                begin
                    rx_fill_next = rx_fill_reg - CW'(1);
                    rx_rd_en     = 1'b1;
                    rx_rd_addr   = rx_fill_next[IW-1:0];
                end
                else
                begin
                    rx_empty_rd = 1'b1;
                    rx_empty_c  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            tx_total_reg    <= '0;
            tx_next_reg     <= '0;
            rx_expected_reg <= '0;
            rx_fill_reg     <= '0;
            in_progress_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                tx_total_reg    <= tx_total_next;
                tx_next_reg     <= tx_next_next;
                rx_expected_reg <= rx_expected_next;
                rx_fill_reg     <= rx_fill_next;
                in_progress_reg <= in_progress_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
    end

    // Buffers and result payload; buffer reads land directly in the result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (tx_wr_en)
            begin
                tx_mem[tx_wr_addr] <= tx_wr_data;
            end
            if (rx_wr_en)
            begin
                rx_mem[rx_wr_addr] <= f_byte;
            end
            if (tx_rd_en)
            begin
                tx_byte_reg <= tx_mem[tx_rd_addr];
            end
            else
            begin
                tx_byte_reg <= 8'h00;
            end
            if (rx_rd_en)
            begin
                rx_byte_reg <= rx_mem[rx_rd_addr];
            end
            else if (rx_empty_rd)
            begin
                rx_byte_reg <= RX_EMPTY_BYTE;
            end
            else
            begin
                rx_byte_reg <= 8'h00;
            end
            action_reg   <= action_c;
            busy_reg     <= in_progress_next;
            has_data_reg <= (rx_fill_next != '0);
            rx_empty_reg <= rx_empty_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, rx_empty_reg, has_data_reg, busy_reg,
                       rx_byte_reg, tx_byte_reg, action_reg};

`ifndef SYNTHESIS
    // Fill count never passes the buffer depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fill_reg <= CW'(BUFFER_DEPTH))
        else $error("receive fill count beyond buffer depth");

    // An empty pop returns the marker byte and reports no data left
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rx_empty_reg) |->
        (rx_byte_reg == RX_EMPTY_BYTE && !has_data_reg && action_reg == ACT_NONE))
        else $error("empty pop result inconsistent");

    // A processed request always shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");

    // A send never targets a slot beyond the transmit total
    a_send_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && action_c == ACT_SEND) |=> (tx_next_reg <= tx_total_reg))
        else $error("transmit pointer passed transmit total");
`endif

endmodule

### test/i2c_master_transaction_sequencer_tb.sv
// Self-checking testbench for i2c_master_transaction_sequencer: directed requests, then
// random write/read/pop traffic checked against a predictor of the sequencer.
// Depends on i2c_seq_pkg and the RTL top level only.
`timescale 1ns / 100ps

module i2c_master_transaction_sequencer_tb;
    import i2c_seq_pkg::*;

    localparam int SEQ_DEPTH    = 16;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT  = 100;

    // Kinds the block does not define; they must leave it untouched
    localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
    localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic [7:0] data;
        logic [6:0] addr;
        logic [4:0] count;
        logic [7:0] status;
    } request_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
        logic       busy;
        logic       has_data;
        logic       rx_empty;
    } result_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        result_t  want;
    } step_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Predicted sequencer state
    logic [7:0] tx_image [SEQ_DEPTH];
    logic [7:0] rx_image [SEQ_DEPTH];
    bit         tx_written [SEQ_DEPTH];
    int         tx_len;
    int         tx_pos;
    int         rx_len;
    int         rx_count;
    bit         seq_busy;

    result_t    pending_results [$];
    int         fault_count;
    int         issued;
    int         results_seen;
    bit         steady;
    bit         hold_out_req;

    i2c_master_transaction_sequencer #(.BUFFER_DEPTH(SEQ_DEPTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("i2c_master_transaction_sequencer: mismatch");
        $finish;
    end

    function automatic request_t rq(logic [2:0] kind, logic [3:0] slot, logic [7:0] data,
                                    logic [6:0] addr, logic [4:0] count, logic [7:0] status);
        request_t r;
        r = '{kind, slot, data, addr, count, status};
        return r;
    endfunction

    function automatic result_t rs(action_t act, logic [7:0] txb, logic [7:0] rxb,
                                   logic busy, logic has, logic empty);
        result_t r;
        r = '{act, txb, rxb, busy, has, empty};
        return r;
    endfunction

    // Received byte lands in the buffer unless it is already full
    function automatic void store_rx(logic [7:0] b);
        if (rx_count < SEQ_DEPTH)
        begin
            rx_image[rx_count] = b;
            rx_count++;
        end
    endfunction

    // Next bus action and flags for one request; updates the predicted state
    function automatic result_t sequencer_step(request_t r);
        result_t res;
        int      lim;
        int      idx;
        res = '0;
        res.action = ACT_NONE;
        case (r.kind)
            KIND_LOAD:
            begin
                idx = int'(r.slot) + 1;
                if (idx < SEQ_DEPTH)
                begin
                    tx_image[idx]   = r.data;
                    tx_written[idx] = 1'b1;
                end
            end
            KIND_WRITE:
            begin
                lim = (int'(r.count) > SEQ_DEPTH - 1) ? SEQ_DEPTH - 1 : int'(r.count);
                tx_image[0] = {r.addr, 1'b0};
                tx_len      = lim + 1;
                seq_busy    = 1'b1;
                res.action  = ACT_START;
            end
            KIND_READ:
            begin
                lim = (int'(r.count) > SEQ_DEPTH) ? SEQ_DEPTH : int'(r.count);
                tx_image[0] = {r.addr, 1'b1};
                tx_len      = 1;
                rx_len      = lim;
                seq_busy    = 1'b1;
                res.action  = ACT_START;
            end
            KIND_EVENT:
            begin
                if (r.status == ST_START || r.status == ST_RESTART)
                    tx_pos = 0;
                if (r.status == ST_START || r.status == ST_RESTART ||
                    r.status == ST_SLA_W_ACK || r.status == ST_DAT_W_ACK)
                begin
                    if (tx_pos < tx_len && tx_pos < SEQ_DEPTH)
                    begin
                        res.tx_byte = tx_image[tx_pos];
                        res.action  = ACT_SEND;
                        tx_pos++;
                    end
                    else
                    begin
                        seq_busy   = 1'b0;
                        res.action = ACT_STOP;
                    end
                end
                else if (r.status == ST_SLA_R_ACK)
                begin
                    rx_count   = 0;
                    res.action = (rx_len == 0 || rx_len > 1) ? ACT_ACK : ACT_NACK;
                end
                else if (r.status == ST_DAT_R_ACK)
                begin
                    store_rx(r.data);
                    res.action = (rx_len >= 1 && rx_count + 1 < rx_len) ? ACT_ACK : ACT_NACK;
                end
                else if (r.status == ST_DAT_R_NAK)
                begin
                    store_rx(r.data);
                    seq_busy   = 1'b0;
                    res.action = ACT_STOP;
                end
                else if (r.status == ST_ARB_LOST)
                begin
                    seq_busy   = 1'b0;
                    res.action = ACT_RESTART;
                end
                else
                begin
                    seq_busy   = 1'b0;
                    res.action = ACT_STOP;
                end
            end
            KIND_POP:
            begin
                // last byte in comes out first
                if (rx_count > 0)
                begin
                    rx_count--;
                    res.rx_byte = rx_image[rx_count];
                end
                else
                begin
                    res.rx_byte  = RX_EMPTY_BYTE;
                    res.rx_empty = 1'b1;
                end
            end
            default: ;
        endcase
        res.busy     = seq_busy;
        res.has_data = (rx_count > 0);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fault_count++;
        if (fault_count <= PRINT_LIMIT)
            $display("%0t ns: result %0d %s: got 0x%0h, want 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    // Result checker: each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("with none outstanding", int'(m_tdata), 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.action)
                    report_mismatch("action", int'(m_tdata[2:0]), int'(want.action));
                if (m_tdata[10:3] != want.tx_byte)
                    report_mismatch("tx_byte", int'(m_tdata[10:3]), int'(want.tx_byte));
                if (m_tdata[18:11] != want.rx_byte)
                    report_mismatch("rx_byte", int'(m_tdata[18:11]), int'(want.rx_byte));
                if (m_tdata[19] != want.busy)
                    report_mismatch("busy_res", int'(m_tdata[19]), int'(want.busy));
                if (m_tdata[20] != want.has_data)
                    report_mismatch("has_data", int'(m_tdata[20]), int'(want.has_data));
                if (m_tdata[21] != want.rx_empty)
                    report_mismatch("rx_empty", int'(m_tdata[21]), int'(want.rx_empty));
                if (m_tdata[23:22] != 2'b00)
                    report_mismatch("pad bits", int'(m_tdata[23:22]), 0);
            end
            results_seen++;
        end
    end

    // Result side: random back-pressure, one long hold while the sender keeps going
    initial
    begin
        bit hold_done;
        int n;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_out_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    // Drive one request from a falling edge until it is taken; predict on acceptance
    task automatic offer(request_t r, logic typed, result_t want);
        result_t predicted;
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.status, r.count, r.addr, r.data, r.slot};
        s_tuser  <= r.kind;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = sequencer_step(r);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 10))
            0:       return ST_START;
            1:       return ST_RESTART;
            2:       return ST_SLA_W_ACK;
            3:       return ST_SLA_W_NAK;
            4:       return ST_DAT_W_ACK;
            5:       return ST_DAT_W_NAK;
            6:       return ST_ARB_LOST;
            7:       return ST_SLA_R_ACK;
            8:       return ST_SLA_R_NAK;
            9:       return ST_DAT_R_ACK;
            default: return ST_DAT_R_NAK;
        endcase
    endfunction

    function automatic request_t noise_req(logic [2:0] kind);
        request_t r;
        r.kind   = kind;
        r.slot   = 4'($urandom_range(0, 15));
        r.data   = 8'($urandom);
        r.addr   = 7'($urandom);
        r.count  = 5'($urandom);
        r.status = ($urandom_range(0, 1) == 1) ? pick_code() : 8'($urandom);
        return r;
    endfunction

    // Random request path; keeps the bus from sending a data slot never loaded
    task automatic issue(request_t r);
        int idx;
        if (r.kind == KIND_EVENT &&
            (r.status == ST_START || r.status == ST_RESTART ||
             r.status == ST_SLA_W_ACK || r.status == ST_DAT_W_ACK))
        begin
            idx = (r.status == ST_START || r.status == ST_RESTART) ? 0 : tx_pos;
            if (idx > 0 && idx < tx_len && idx < SEQ_DEPTH && !tx_written[idx])
                r.status = ST_DAT_W_NAK;
        end
        // ignored requests do not count toward the total
        if (r.kind <= KIND_POP && !(r.kind == KIND_LOAD && int'(r.slot) + 1 >= SEQ_DEPTH))
            issued++;
        offer(r, 1'b0, '0);
    endtask

    // Load, start write, address and data phases, occasionally cut short by a bus error
    task automatic run_write();
        request_t r;
        int       n;
        int       eff;
        int       i;
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 15);
        eff = (n > SEQ_DEPTH - 1) ? SEQ_DEPTH - 1 : n;
        for (i = 1; i <= eff; i++)
        begin
            if (!tx_written[i] || $urandom_range(0, 2) == 0)
            begin
                r = noise_req(KIND_LOAD);
                r.slot = 4'(i - 1);
                issue(r);
            end
        end
        r = noise_req(KIND_WRITE);
        r.count = 5'(n);
        issue(r);
        r = noise_req(KIND_EVENT);
        r.status = ($urandom_range(0, 4) == 0) ? ST_RESTART : ST_START;
        issue(r);
        for (i = 0; i <= eff; i++)
        begin
            r = noise_req(KIND_EVENT);
            r.status = (i == 0) ? ST_SLA_W_ACK : ST_DAT_W_ACK;
            if ($urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       r.status = ST_SLA_W_NAK;
                    1:       r.status = ST_DAT_W_NAK;
                    default: r.status = ST_ARB_LOST;
                endcase
                issue(r);
                break;
            end
            issue(r);
        end
    endtask

    // Start read, address, data bytes (sometimes past the buffer), then pops
    task automatic run_read();
        request_t r;
        int       n;
        int       e;
        int       k;
        int       i;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
        e = (n > SEQ_DEPTH) ? SEQ_DEPTH : n;
        r = noise_req(KIND_READ);
        r.count = 5'(n);
        issue(r);
        r = noise_req(KIND_EVENT);
        r.status = ST_START;
        issue(r);
        r = noise_req(KIND_EVENT);
        r.status = ($urandom_range(0, 11) == 0) ? ST_SLA_R_NAK : ST_SLA_R_ACK;
        issue(r);
        if (r.status == ST_SLA_R_ACK)
        begin
            k = (e == 0) ? 1 : e - 1;
            if ($urandom_range(0, 9) == 0)
                k += $urandom_range(1, 4);
            for (i = 0; i < k; i++)
            begin
                r = noise_req(KIND_EVENT);
                r.status = ST_DAT_R_ACK;
                issue(r);
            end
            r = noise_req(KIND_EVENT);
            r.status = ST_DAT_R_NAK;
            issue(r);
        end
        k = $urandom_range(0, rx_count + 2);
        for (i = 0; i < k; i++)
            issue(noise_req(KIND_POP));
    endtask

    initial
    begin
        step_row_t rows [$];
        int        pick;

        // Directed requests; typed expectations where they are obvious
        rows.push_back('{rq(KIND_POP, 4'd0, 8'h00, 7'h00, 5'd0, 8'h00), 1'b1,
                         rs(ACT_NONE, 8'h00, RX_EMPTY_BYTE, 1'b0, 1'b0, 1'b1)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_START), 1'b1,
                         rs(ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_LOAD, 4'd0, 8'h00, 7'h7F, 5'd31, 8'hFF), 1'b1,
                         rs(ACT_NONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_LOAD, 4'd14, 8'hFF, 7'h00, 5'd0, 8'h00), 1'b1,
                         rs(ACT_NONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        // slot past the end of the buffer is dropped
        rows.push_back('{rq(KIND_LOAD, 4'd15, 8'hAA, 7'h00, 5'd0, 8'h00), 1'b1,
                         rs(ACT_NONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_LOAD, 4'd1, 8'h5A, 7'h2A, 5'd5, 8'h18), 1'b0, '0});
        rows.push_back('{rq(KIND_WRITE, 4'd0, 8'h00, 7'h7F, 5'd1, 8'h00), 1'b1,
                         rs(ACT_START, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_START), 1'b1,
                         rs(ACT_SEND, 8'hFE, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_SLA_W_ACK), 1'b1,
                         rs(ACT_SEND, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_DAT_W_ACK), 1'b1,
                         rs(ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        // write count saturates; lost arbitration ends it before any data goes out
        rows.push_back('{rq(KIND_WRITE, 4'd0, 8'h00, 7'h00, 5'd31, 8'h00), 1'b1,
                         rs(ACT_START, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_ARB_LOST), 1'b1,
                         rs(ACT_RESTART, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        // repeated start while idle still resends the address byte
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_RESTART), 1'b0, '0});
        // zero-length read: ACK after address, NACK after the first byte
        rows.push_back('{rq(KIND_READ, 4'd0, 8'h00, 7'h55, 5'd0, 8'h00), 1'b1,
                         rs(ACT_START, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_SLA_R_ACK), 1'b1,
                         rs(ACT_ACK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'hFF, 7'h00, 5'd0, ST_DAT_R_ACK), 1'b1,
                         rs(ACT_NACK, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_DAT_R_NAK), 1'b1,
                         rs(ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0)});
        rows.push_back('{rq(KIND_POP, 4'd0, 8'h00, 7'h00, 5'd0, 8'h00), 1'b0, '0});
        rows.push_back('{rq(KIND_POP, 4'd0, 8'h00, 7'h00, 5'd0, 8'h00), 1'b0, '0});
        rows.push_back('{rq(KIND_POP, 4'd0, 8'h00, 7'h00, 5'd0, 8'h00), 1'b1,
                         rs(ACT_NONE, 8'h00, RX_EMPTY_BYTE, 1'b0, 1'b0, 1'b1)});
        // read count saturates; address NAK and error codes stop the transfer
        rows.push_back('{rq(KIND_READ, 4'd0, 8'h00, 7'h03, 5'd31, 8'h00), 1'b1,
                         rs(ACT_START, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_SLA_R_ACK), 1'b1,
                         rs(ACT_ACK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, ST_SLA_R_NAK), 1'b1,
                         rs(ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'hFF, 7'h00, 5'd0, ST_SLA_W_NAK), 1'b1,
                         rs(ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_EVENT, 4'd0, 8'h00, 7'h00, 5'd0, 8'hFF), 1'b1,
                         rs(ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});
        rows.push_back('{rq(KIND_RESERVED_HI, 4'd15, 8'hFF, 7'h7F, 5'd31, 8'hFF), 1'b1,
                         rs(ACT_NONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)});

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            offer(rows[i].req, rows[i].typed, rows[i].want);

        // Random traffic: mostly well-formed transfers, some noise and pop bursts
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued >= 150)
                hold_out_req = 1'b1;
            steady = (issued >= 400 && issued < 550);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                run_write();
            else if (pick < 80)
                run_read();
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 9) == 0)
                        issue(noise_req(3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI))));
                    else
                        issue(noise_req(3'($urandom_range(KIND_LOAD, KIND_POP))));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    issue(noise_req(KIND_POP));
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("i2c_master_transaction_sequencer: match");
        else
            $display("i2c_master_transaction_sequencer: mismatch");
        $finish;
    end

endmodule
